>>> src/thi_pkg.sv
// ----------------------------------------------------------------------------
// thi_pkg
// Types and codes shared by the hash index: command and result words,
// table entry layout, opcodes, status codes and slot marks.
// ----------------------------------------------------------------------------
package thi_pkg;

	localparam int HASH_BITS  = 32;
	localparam int INDEX_BITS = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_ERASE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [2:0] STAT_INSERTED   = 3'd0;
	localparam logic [2:0] STAT_PRESENT    = 3'd1;
	localparam logic [2:0] STAT_INDEX_ZERO = 3'd2;
	localparam logic [2:0] STAT_FULL       = 3'd3;
	localparam logic [2:0] STAT_ERASED     = 3'd4;
	localparam logic [2:0] STAT_NOT_FOUND  = 3'd5;
	localparam logic [2:0] STAT_CLEARED    = 3'd6;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_USED  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [HASH_BITS-1:0]  name_hash;
		logic [INDEX_BITS-1:0] entity_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] slot;
		logic       rebuild_requested;
	} result_t;

	typedef struct packed {
		logic [1:0]            mark;
		logic [HASH_BITS-1:0]  key;
		logic [INDEX_BITS-1:0] value;
	} entry_t;

endpackage

>>> src/thi_ram.sv
// ----------------------------------------------------------------------------
// thi_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module thi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/thi_hash_mod.sv
// ----------------------------------------------------------------------------
// thi_hash_mod
// Home slot of a hash: hash modulo the slot count. A power-of-two count
// takes the low hash bits into the result register; any other count
// registers a constant-reciprocal quotient, then a low-bit back-multiply.
// ----------------------------------------------------------------------------
module thi_hash_mod import thi_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [HASH_BITS-1:0]     hash,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] pos
);

	localparam int AW = $clog2(SLOTS);
	localparam int SH = HASH_BITS + AW;
	localparam int PW = 2 * HASH_BITS + 1;
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [HASH_BITS:0] RECIP =
		(HASH_BITS + 1)'(((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
	localparam logic [AW-1:0] MOD_LOW = AW'(SLOTS);

	logic          run_q;
	logic          done_q;
	logic [AW-1:0] quo_s1;
	logic [AW-1:0] low_s1;
	logic [AW-1:0] rem_q;
	logic [PW-1:0] prod;
	logic [AW-1:0] back;

	always_comb begin
		prod = PW'(hash) * PW'(RECIP);
		back = AW'(quo_s1 * MOD_LOW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			run_q  <= 1'b0;
			if (go) begin
				if (POW2) begin
					rem_q  <= hash[AW-1:0];
					done_q <= 1'b1;
				end else begin
					quo_s1 <= prod[SH +: AW];
					low_s1 <= hash[AW-1:0];
					run_q  <= 1'b1;
				end
			end else if (run_q) begin
				rem_q  <= low_s1 - back;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign pos  = rem_q;

endmodule

>>> src/tombstone_hash_index_top.sv
// ----------------------------------------------------------------------------
// tombstone_hash_index_top
// Open-addressing hash index with linear probing and tombstones.
//
// Commands enter on cmd when start is high and busy is low. Each command
// yields one result word on result, valid for the single cycle in which
// done is high; the receiver takes it then and cannot hold it off.
// The home slot is found by the hash modulo unit. The probe then reads the
// table RAM one slot per cycle, stopping at an empty slot, a match or
// after a full pass of the table. An insert or erase thus passes through
// the modulo state and then the probe. Index-zero inserts and the unused
// opcode answer the cycle after acceptance. A clear sweeps the RAM one
// slot per cycle and then reports its result. After reset the same sweep
// runs (busy high, no result) before the first command is taken.
// rebuild_requested reflects the tombstone count after the command.
// ----------------------------------------------------------------------------
module tombstone_hash_index_top import thi_pkg::*; #(
	parameter int TABLE_SLOTS = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int TW = $clog2(TABLE_SLOTS + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);
	localparam logic [TW-1:0] TOMB_MAX  = TW'(TABLE_SLOTS);
	localparam logic [TW-1:0] QUARTER   = TW'(TABLE_SLOTS / 4);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MOD, ST_PROBE} state_t;

	state_t                state_q;
	logic [1:0]            op_q;
	logic [HASH_BITS-1:0]  key_q;
	logic [INDEX_BITS-1:0] val_q;
	logic [AW-1:0]         issue_q;
	logic [AW-1:0]         addr_s1;
	logic                  valid_s1;
	logic [AW-1:0]         cnt_q;
	logic                  have_tomb_q;
	logic [AW-1:0]         tomb_pos_q;
	logic [TW-1:0]         tomb_q;
	logic [AW-1:0]         clr_q;
	logic                  report_q;
	logic                  done_q;
	logic [2:0]            status_q;
	logic [7:0]            slot_q;

	logic                  mod_go;
	logic                  mod_done;
	logic [AW-1:0]         mod_pos;

	logic                  we;
	logic [AW-1:0]         waddr;
	entry_t                wdata;
	entry_t                rd;
	logic [AW-1:0]         issue_next;

	logic                  hit;
	logic                  finish;
	logic [2:0]            fin_status;
	logic [AW-1:0]         fin_slot;
	logic                  tomb_dec;
	logic                  tomb_inc;

	thi_hash_mod #(.SLOTS(TABLE_SLOTS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mod_go),
		.hash   (cmd.name_hash),
		.done   (mod_done),
		.pos    (mod_pos)
	);

	thi_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_SLOTS)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (issue_q),
		.rdata (rd)
	);

	assign mod_go = (state_q == ST_IDLE) && start &&
		((cmd.opcode == OP_ERASE) ||
		 ((cmd.opcode == OP_INSERT) && (cmd.entity_index != '0)));

	assign issue_next = (issue_q == LAST_SLOT) ? '0 : issue_q + 1'b1;
	assign hit = (rd.key == key_q) && (rd.value == val_q);

	always_comb begin
		finish     = 1'b0;
		fin_status = STAT_NOT_FOUND;
		fin_slot   = '0;
		tomb_dec   = 1'b0;
		tomb_inc   = 1'b0;
		we         = 1'b0;
		waddr      = clr_q;
		wdata      = '{mark: MARK_EMPTY, key: '0, value: '0};
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
		end else if ((state_q == ST_PROBE) && valid_s1) begin
			if (op_q == OP_INSERT) begin
				if (rd.mark == MARK_EMPTY) begin
					finish     = 1'b1;
					fin_status = STAT_INSERTED;
					fin_slot   = have_tomb_q ? tomb_pos_q : addr_s1;
					tomb_dec   = have_tomb_q && (tomb_q != '0);
					we         = 1'b1;
					waddr      = fin_slot;
					wdata      = '{mark: MARK_USED, key: key_q, value: val_q};
				end else if ((rd.mark != MARK_TOMB) && hit) begin
					finish     = 1'b1;
					fin_status = STAT_PRESENT;
					fin_slot   = addr_s1;
				end else if (cnt_q == LAST_SLOT) begin
					finish     = 1'b1;
					fin_status = STAT_FULL;
				end
			end else begin
				if (rd.mark == MARK_EMPTY) begin
					finish     = 1'b1;
					fin_status = STAT_NOT_FOUND;
				end else if ((rd.mark == MARK_USED) && hit) begin
					finish     = 1'b1;
					fin_status = STAT_ERASED;
					fin_slot   = addr_s1;
					tomb_inc   = tomb_q < TOMB_MAX;
					we         = 1'b1;
					waddr      = addr_s1;
					wdata      = '{mark: MARK_TOMB, key: '0, value: '0};
				end else if (cnt_q == LAST_SLOT) begin
					finish     = 1'b1;
					fin_status = STAT_NOT_FOUND;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			report_q    <= 1'b0;
			done_q      <= 1'b0;
			tomb_q      <= '0;
			valid_s1    <= 1'b0;
			have_tomb_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= (clr_q == LAST_SLOT) ? '0 : clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
						if (report_q) begin
							done_q   <= 1'b1;
							status_q <= STAT_CLEARED;
							slot_q   <= '0;
						end
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q  <= cmd.opcode;
						key_q <= cmd.name_hash;
						val_q <= cmd.entity_index;
						case (cmd.opcode)
							OP_INSERT: begin
								if (cmd.entity_index == '0) begin
									done_q   <= 1'b1;
									status_q <= STAT_INDEX_ZERO;
									slot_q   <= '0;
								end else begin
									state_q <= ST_MOD;
								end
							end
							OP_ERASE: begin
								state_q <= ST_MOD;
							end
							OP_CLEAR: begin
								state_q  <= ST_CLEAR;
								clr_q    <= '0;
								report_q <= 1'b1;
								tomb_q   <= '0;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= STAT_NOT_FOUND;
								slot_q   <= '0;
							end
						endcase
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						issue_q     <= mod_pos;
						valid_s1    <= 1'b0;
						cnt_q       <= '0;
						have_tomb_q <= 1'b0;
						state_q     <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					issue_q  <= issue_next;
					addr_s1  <= issue_q;
					valid_s1 <= 1'b1;
					if (valid_s1) begin
						if (finish) begin
							state_q  <= ST_IDLE;
							valid_s1 <= 1'b0;
							done_q   <= 1'b1;
							status_q <= fin_status;
							slot_q   <= 8'(fin_slot);
							if (tomb_dec) begin
								tomb_q <= tomb_q - 1'b1;
							end else if (tomb_inc) begin
								tomb_q <= tomb_q + 1'b1;
							end
						end else begin
							cnt_q <= cnt_q + 1'b1;
							if ((rd.mark == MARK_TOMB) && !have_tomb_q) begin
								have_tomb_q <= 1'b1;
								tomb_pos_q  <= addr_s1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = '{status: status_q, slot: slot_q,
		rebuild_requested: (tomb_q > QUARTER)};

	a_tomb_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tomb_q <= TOMB_MAX)
		else $error("tombstone count above capacity");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word produced neither work nor result");

	a_insert_wrote: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STAT_INSERTED)) |-> $past(we))
		else $error("insert reported without table write");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q != ST_IDLE))
		else $error("table write while idle");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STAT_CLEARED)) |-> (tomb_q == '0))
		else $error("clear left tombstones counted");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tombstone_hash_index_top. Each command word is
// played into a local copy of the table (marks, keys, values, tombstone
// count) as it is accepted, and the predicted result word is queued. Every
// strobed result is compared field by field with the oldest prediction.
// Tests: directed corner cases, a full table driven until every slot is a
// tombstone, and random traffic that mixes fresh keys with live pairs.
// ----------------------------------------------------------------------------
module testbench;
	import thi_pkg::*;

	localparam int SLOTS        = 256;
	localparam int STALL_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 300;
	localparam int REPORT_LIMIT = 10;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    done;
	result_t result;

	logic [1:0]  tbl_mark  [SLOTS];
	logic [31:0] tbl_key   [SLOTS];
	logic [15:0] tbl_value [SLOTS];
	int          tomb_total;

	cmd_t    live_pairs[$];
	result_t expected_results[$];
	int      mismatches;
	int      stall_cycles;
	bit      steady;

	tombstone_hash_index_top #(.TABLE_SLOTS(SLOTS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic result_t apply_command(input cmd_t c);
		result_t r;
		int      pos;
		int      tomb_pos;
		int      n;
		int      k;
		bit      have_tomb;
		bit      finished;
		r         = '0;
		r.status  = STAT_NOT_FOUND;
		pos       = int'(c.name_hash % 32'(SLOTS));
		tomb_pos  = 0;
		have_tomb = 1'b0;
		finished  = 1'b0;
		case (c.opcode)
			OP_INSERT: begin
				if (c.entity_index == '0) begin
					r.status = STAT_INDEX_ZERO;
				end else begin
					r.status = STAT_FULL;
					for (n = 0; n < SLOTS && !finished; n++) begin
						if (tbl_mark[pos] == MARK_EMPTY) begin
							if (have_tomb) begin
								pos = tomb_pos;
								if (tomb_total > 0)
									tomb_total--;
							end
							tbl_mark[pos]  = MARK_USED;
							tbl_key[pos]   = c.name_hash;
							tbl_value[pos] = c.entity_index;
							r.status       = STAT_INSERTED;
							r.slot         = pos[7:0];
							finished       = 1'b1;
							live_pairs.push_back(c);
						end else if (tbl_mark[pos] == MARK_TOMB) begin
							if (!have_tomb) begin
								have_tomb = 1'b1;
								tomb_pos  = pos;
							end
						end else if (tbl_key[pos] == c.name_hash &&
								tbl_value[pos] == c.entity_index) begin
							r.status = STAT_PRESENT;
							r.slot   = pos[7:0];
							finished = 1'b1;
						end
						if (!finished)
							pos = (pos + 1) % SLOTS;
					end
				end
			end
			OP_ERASE: begin
				for (n = 0; n < SLOTS && !finished; n++) begin
					if (tbl_mark[pos] == MARK_EMPTY) begin
						finished = 1'b1;
					end else if (tbl_mark[pos] == MARK_USED &&
							tbl_key[pos] == c.name_hash &&
							tbl_value[pos] == c.entity_index) begin
						tbl_mark[pos]  = MARK_TOMB;
						tbl_key[pos]   = '0;
						tbl_value[pos] = '0;
						if (tomb_total < SLOTS)
							tomb_total++;
						r.status = STAT_ERASED;
						r.slot   = pos[7:0];
						finished = 1'b1;
						for (k = 0; k < live_pairs.size(); k++) begin
							if (live_pairs[k].name_hash == c.name_hash &&
									live_pairs[k].entity_index == c.entity_index) begin
								live_pairs.delete(k);
								break;
							end
						end
					end else begin
						pos = (pos + 1) % SLOTS;
					end
				end
			end
			OP_CLEAR: begin
				for (n = 0; n < SLOTS; n++) begin
					tbl_mark[n]  = MARK_EMPTY;
					tbl_key[n]   = '0;
					tbl_value[n] = '0;
				end
				tomb_total = 0;
				live_pairs.delete();
				r.status   = STAT_CLEARED;
			end
			default: r.status = STAT_NOT_FOUND;
		endcase
		r.rebuild_requested = (tomb_total > SLOTS / 4);
		return r;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	task automatic send_word(input logic [1:0] op, input logic [31:0] h,
			input logic [15:0] i);
		cmd_t c;
		cmd_t junk;
		int   gap;
		c.opcode       = op;
		c.name_hash    = h;
		c.entity_index = i;
		if (!steady && $urandom_range(99) < 19) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				junk.opcode       = 2'($urandom);
				junk.name_hash    = $urandom;
				junk.entity_index = 16'($urandom);
				start <= 1'b0;
				cmd   <= junk;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(apply_command(c));
	endtask

	task automatic test_directed_cases();
		send_word(OP_INSERT, 32'h0000_0000, 16'h0000);
		send_word(OP_INSERT, 32'h0000_0000, 16'h0001);
		send_word(OP_INSERT, 32'h0000_0000, 16'h0001);
		send_word(OP_INSERT, 32'h0000_0000, 16'hFFFF);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(OP_INSERT, 32'h1234_56FF, 16'h8000);
		send_word(OP_ERASE,  32'h0000_0000, 16'h0000);
		send_word(OP_ERASE,  32'h0000_0000, 16'h0001);
		send_word(OP_ERASE,  32'h0000_0000, 16'h0001);
		send_word(OP_INSERT, 32'h0000_0000, 16'hFFFF);
		send_word(OP_INSERT, 32'h0000_0000, 16'h0001);
		send_word(OP_ERASE,  32'hAAAA_5555, 16'h5555);
		send_word(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(OP_UNUSED, 32'h0000_0000, 16'h0000);
		send_word(OP_ERASE,  32'hFFFF_FFFF, 16'hFFFF);
		send_word(OP_INSERT, 32'h5555_AAFF, 16'hAAAA);
		send_word(OP_CLEAR,  32'hFFFF_FFFF, 16'hFFFF);
		send_word(OP_ERASE,  32'h0000_0000, 16'h0001);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 16'h0001);
		send_word(OP_CLEAR,  32'h0000_0000, 16'h0000);
	endtask

	task automatic test_full_table();
		cmd_t p;
		int   n;
		for (n = 0; n < SLOTS; n++)
			send_word(OP_INSERT, {24'($urandom), 8'(n)}, 16'($urandom_range(1, 65535)));
		send_word(OP_INSERT, $urandom, 16'($urandom_range(1, 65535)));
		send_word(OP_ERASE, $urandom, 16'h0000);
		p = live_pairs[10];
		send_word(OP_ERASE, p.name_hash, p.entity_index);
		send_word(OP_INSERT, $urandom, 16'($urandom_range(1, 65535)));
		p = live_pairs[20];
		send_word(OP_INSERT, p.name_hash, p.entity_index);
		while (live_pairs.size() > 0) begin
			p = live_pairs[0];
			send_word(OP_ERASE, p.name_hash, p.entity_index);
		end
		send_word(OP_INSERT, p.name_hash, p.entity_index);
		send_word(OP_ERASE, p.name_hash, p.entity_index);
		send_word(OP_CLEAR, $urandom, 16'($urandom));
	endtask

	task automatic test_random_traffic(input int count);
		cmd_t        p;
		int          n;
		int          pick;
		logic [31:0] h;
		logic [15:0] i;
		for (n = 0; n < count; n++) begin
			steady = (n >= 700 && n < 1000);
			pick   = $urandom_range(99);
			h      = $urandom;
			i      = 16'($urandom_range(1, 65535));
			if ($urandom_range(1))
				h[7:0] = 8'($urandom_range(0, 40));
			if (live_pairs.size() > 0)
				p = live_pairs[$urandom_range(live_pairs.size() - 1)];
			else
				p = '{opcode: OP_INSERT, name_hash: h, entity_index: i};
			if (pick == 0 || ((tomb_total > SLOTS / 4 || live_pairs.size() > 200) &&
					$urandom_range(9) == 0))
				send_word(OP_CLEAR, $urandom, 16'($urandom));
			else if (pick < 36)
				send_word(OP_INSERT, h, i);
			else if (pick < 66)
				send_word(OP_ERASE, p.name_hash, p.entity_index);
			else if (pick < 76)
				send_word(OP_INSERT, p.name_hash, p.entity_index);
			else if (pick < 86)
				send_word(OP_ERASE, h, i);
			else if (pick < 89)
				send_word(OP_INSERT, p.name_hash, i);
			else if (pick < 92)
				send_word(OP_ERASE, p.name_hash, i);
			else if (pick < 96)
				send_word($urandom_range(1) ? OP_INSERT : OP_ERASE, h, 16'h0000);
			else
				send_word(OP_UNUSED, $urandom, 16'($urandom));
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				flag_error($sformatf("unexpected result: status %0d slot %0d rebuild %0b",
					result.status, result.slot, result.rebuild_requested));
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status || result.slot !== want.slot ||
						result.rebuild_requested !== want.rebuild_requested)
					flag_error($sformatf(
						"mismatch: expected status %0d slot %0d rebuild %0b, got %0d %0d %0b",
						want.status, want.slot, want.rebuild_requested,
						result.status, result.slot, result.rebuild_requested));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int n;
		mismatches   = 0;
		stall_cycles = 0;
		steady       = 1'b0;
		tomb_total   = 0;
		for (n = 0; n < SLOTS; n++) begin
			tbl_mark[n]  = MARK_EMPTY;
			tbl_key[n]   = '0;
			tbl_value[n] = '0;
		end
		arst_n <= 1'b0;
		start  <= 1'b0;
		cmd    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_full_table();
		test_random_traffic(1360);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
